/* hdl/iirf_pkg.sv */
// Shared types, widths and register codes for the direct-form I IIR filter.
package iirf_pkg;

  localparam int ORDER          = 3;
  localparam int MAX_ORDER      = 3;
  localparam int NTAPS          = MAX_ORDER + 1;
  localparam int COEF_FRAC_BITS = 14;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 18;
  localparam int NUM_REGS       = 7;
  localparam int CFG_IDX_W      = $clog2(NUM_REGS + 1);

  localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
  // seven products summed
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;

  localparam coef_t COEF_ONE = coef_t'(1 << COEF_FRAC_BITS);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_COEF_0 = 0,
    REG_FF_COEF_1 = 1,
    REG_FF_COEF_2 = 2,
    REG_FF_COEF_3 = 3,
    REG_FB_COEF_1 = 4,
    REG_FB_COEF_2 = 5,
    REG_FB_COEF_3 = 6
  } cfg_reg_e;

  typedef struct packed {
    logic load;   // capture the tap product
    logic shift;  // advance the input history
  } cell_ctrl_t;

  typedef struct packed {
    logic a_en;
    logic b_en;
    logic y_en;
    logic a_vld;
    logic b_vld;
  } pipe_ctrl_t;

endpackage

/* hdl/iirf_in_if.sv */
// Input sample channel.
interface iirf_in_if;
  import iirf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* hdl/iirf_out_if.sv */
// Output sample channel.
interface iirf_out_if;
  import iirf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* hdl/iirf_cfg_if.sv */
// Coefficient register write channel.
interface iirf_cfg_if;
  import iirf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/iirf_tap_cell.sv */
// One feedforward tap: input history register and registered coefficient product.
module iirf_tap_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iirf_pkg::cell_ctrl_t ctrl_i,
  input  iirf_pkg::coef_t      coef_i,
  input  iirf_pkg::sample_t    x_i,
  output iirf_pkg::sample_t    x_o,
  output iirf_pkg::prod_t      prod_o
);
  import iirf_pkg::*;

  sample_t x_q;
  prod_t   prod_d;
  prod_t   prod_q;

  assign prod_d = coef_i * x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
    end else if (ctrl_i.shift) begin
      x_q <= x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  assign x_o    = x_q;
  assign prod_o = prod_q;

endmodule

/* hdl/iirf_recursion.sv */
// Feedback path: partial sum, feedback products, saturation and output history.
module iirf_recursion (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iirf_pkg::pipe_ctrl_t ctrl_i,
  input  iirf_pkg::prod_t      ff_prod_i [iirf_pkg::NTAPS],
  input  iirf_pkg::coef_t      fb_coef_i [1:iirf_pkg::MAX_ORDER],
  output iirf_pkg::sample_t    y_o
);
  import iirf_pkg::*;

  sample_t           yh_q [MAX_ORDER];
  sample_t           y_sel3;
  sample_t           y_sel2;
  prod_t             pb3_d;
  prod_t             pb3_q;
  prod_t             q2_d;
  prod_t             q2_q;
  acc_t              sum_d;
  acc_t              sum_q;
  prod_t             p1;
  acc_t              acc;
  logic [SH_W-1:0]   sh;
  sample_t           y_d;

  // Outputs still in the pipeline decide where y[n-3] sits in the history.
  always_comb begin
    case ({ctrl_i.a_vld, ctrl_i.b_vld})
      2'b00:   y_sel3 = yh_q[2];
      2'b11:   y_sel3 = yh_q[0];
      default: y_sel3 = yh_q[1];
    endcase
  end

  assign y_sel2 = ctrl_i.b_vld ? yh_q[0] : yh_q[1];

  assign pb3_d = fb_coef_i[3] * y_sel3;
  assign q2_d  = fb_coef_i[2] * y_sel2;

  assign sum_d = acc_t'(ff_prod_i[0]) + acc_t'(ff_prod_i[1]) + acc_t'(ff_prod_i[2])
               + acc_t'(ff_prod_i[3]) - acc_t'(pb3_q);

  assign p1  = fb_coef_i[1] * yh_q[0];
  assign acc = sum_q - acc_t'(q2_q) - acc_t'(p1);

  // upper bits of the sum are the floor shift
  assign sh = acc[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    if ((&sh[SH_W-1:SAMPLE_WIDTH-1]) || !(|sh[SH_W-1:SAMPLE_WIDTH-1])) begin
      y_d = $signed(sh[SAMPLE_WIDTH-1:0]);
    end else if (sh[SH_W-1]) begin
      y_d = SAMPLE_MIN;
    end else begin
      y_d = SAMPLE_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_en) begin
      pb3_q <= pb3_d;
    end
    if (ctrl_i.b_en) begin
      sum_q <= sum_d;
      q2_q  <= q2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        yh_q[k] <= '0;
      end
    end else if (ctrl_i.y_en) begin
      yh_q[0] <= y_d;
      for (int k = 1; k < MAX_ORDER; k++) begin
        yh_q[k] <= yh_q[k-1];
      end
    end
  end

  assign y_o = yh_q[0];

endmodule

/* hdl/iir_direct_form_filter.sv */
// Top level of the direct-form I IIR filter: registers, tap chain and pipeline control.
//
// Samples enter on in_i and filtered samples leave on out_o, one per input,
// in order. Both are valid/ready channels; a request moves when both are high.
// Coefficients are written on cfg_i (index 0..3 feedforward taps, 4..6
// feedback taps, Q3.14 already scaled by a0); cfg_i is always ready and
// writes to other indexes are dropped. Write them only while no sample is
// in flight.
// A sample taken on in_i passes the product stage, partial-sum stage and
// output register on its way to out_o.
// Throughput: one sample per cycle while out_o is not stalled; set by the
// feedback loop, where y[n-1] is multiplied, added and saturated
// combinationally into the output register.
// Reset clears both histories to zero, empties the pipeline and restores
// the coefficients (ff_coef_0 = 1.0, all others zero).
// A stalled receiver holds the output register; the two earlier stages keep
// filling, and in_i.ready drops once all three hold a sample.
module iir_direct_form_filter (
  input logic            clk_i,
  input logic            rst_ni,
  iirf_in_if.sink        in_i,
  iirf_out_if.source     out_o,
  iirf_cfg_if.sink       cfg_i
);
  import iirf_pkg::*;

  coef_t      ff_q [NTAPS];
  coef_t      fb_q [1:MAX_ORDER];
  coef_t      ff_eff [NTAPS];
  coef_t      fb_eff [1:MAX_ORDER];
  logic       a_vld_q;
  logic       b_vld_q;
  logic       out_vld_q;
  logic       y_en;
  logic       b_en;
  logic       a_en;
  logic       accept;
  cell_ctrl_t cell_ctrl;
  pipe_ctrl_t pipe_ctrl;
  sample_t    x_chain [NTAPS];
  prod_t      ff_prod [NTAPS];
  sample_t    y;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_q[0] <= COEF_ONE;
      for (int k = 1; k < NTAPS; k++) begin
        ff_q[k] <= '0;
      end
      for (int k = 1; k <= MAX_ORDER; k++) begin
        fb_q[k] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FF_COEF_0: ff_q[0] <= $signed(cfg_i.data);
        REG_FF_COEF_1: ff_q[1] <= $signed(cfg_i.data);
        REG_FF_COEF_2: ff_q[2] <= $signed(cfg_i.data);
        REG_FF_COEF_3: ff_q[3] <= $signed(cfg_i.data);
        REG_FB_COEF_1: fb_q[1] <= $signed(cfg_i.data);
        REG_FB_COEF_2: fb_q[2] <= $signed(cfg_i.data);
        REG_FB_COEF_3: fb_q[3] <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // taps above the filter order are kept but weigh nothing
  always_comb begin
    for (int k = 0; k < NTAPS; k++) begin
      ff_eff[k] = (k <= ORDER) ? ff_q[k] : '0;
    end
    for (int k = 1; k <= MAX_ORDER; k++) begin
      fb_eff[k] = (k <= ORDER) ? fb_q[k] : '0;
    end
  end

  // pipeline control
  assign y_en   = b_vld_q && (!out_vld_q || out_o.ready);
  assign b_en   = !b_vld_q || y_en;
  assign a_en   = !a_vld_q || b_en;
  assign accept = in_i.valid && a_en;

  assign in_i.ready = a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_vld_q <= in_i.valid;
      end
      if (b_en) begin
        b_vld_q <= a_vld_q;
      end
      if (y_en) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign cell_ctrl.load  = a_en;
  assign cell_ctrl.shift = accept;

  assign pipe_ctrl.a_en  = a_en;
  assign pipe_ctrl.b_en  = b_en;
  assign pipe_ctrl.y_en  = y_en;
  assign pipe_ctrl.a_vld = a_vld_q;
  assign pipe_ctrl.b_vld = b_vld_q;

  // feedforward tap chain
  assign x_chain[0] = in_i.sample_in;

  for (genvar k = 0; k < NTAPS; k++) begin : g_tap
    if (k < NTAPS - 1) begin : g_mid
      iirf_tap_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .coef_i (ff_eff[k]),
        .x_i    (x_chain[k]),
        .x_o    (x_chain[k+1]),
        .prod_o (ff_prod[k])
      );
    end else begin : g_last
      iirf_tap_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .coef_i (ff_eff[k]),
        .x_i    (x_chain[k]),
        .x_o    (),
        .prod_o (ff_prod[k])
      );
    end
  end

  iirf_recursion u_recursion (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pipe_ctrl),
    .ff_prod_i (ff_prod),
    .fb_coef_i (fb_eff),
    .y_o       (y)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = y;

`ifndef NO_ASSERTIONS
  // a new result only comes from the partial-sum stage
  a_out_from_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(b_vld_q))
    else $error("output valid without a sample in the partial-sum stage");

  // a sample in the product stage moves on when the next stage frees up
  a_a_to_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && b_en) |=> b_vld_q)
    else $error("sample lost between product and partial-sum stages");

  // full pipeline behind a stalled output takes no request
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && b_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while pipeline full and stalled");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the direct-form I IIR filter: directed and random coefficients and samples.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iirf_pkg::*;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef enum int {MIX_FULL, MIX_STABLE, MIX_EXTREME, MIX_IDENTITY} coef_mix_e;

  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(NUM_REGS);
  localparam coef_t    COEF_MAX   = coef_t'((1 << (COEF_WIDTH - 1)) - 1);
  localparam coef_t    COEF_MIN   = coef_t'(-(1 << (COEF_WIDTH - 1)));
  localparam int       CLK_HALF   = 6;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_q  = 1'b0;
  sample_t  in_sample_q = '0;
  logic     out_ready_q = 1'b0;
  logic     cfg_valid_q = 1'b0;
  cfg_idx_t cfg_index_q = '0;
  coef_t    cfg_data_q  = '0;

  iirf_in_if  in_if ();
  iirf_out_if out_if ();
  iirf_cfg_if cfg_if ();

  assign in_if.valid     = in_valid_q;
  assign in_if.sample_in = in_sample_q;
  assign out_if.ready    = out_ready_q;
  assign cfg_if.valid    = cfg_valid_q;
  assign cfg_if.index    = cfg_index_q;
  assign cfg_if.data     = cfg_data_q;

  iir_direct_form_filter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Filter mirror: taps and both histories, most recent first
  coef_t   ff_tap [0:MAX_ORDER];
  coef_t   fb_tap [1:MAX_ORDER];
  sample_t x_hist [0:MAX_ORDER-1];
  sample_t y_hist [0:MAX_ORDER-1];

  sample_t raw_samples[$];
  sample_t filtered_due[$];
  int      fail_count = 0;

  function automatic sample_t predict_filtered(input sample_t x);
    longint acc;
    longint y;
    acc = longint'(ff_tap[0]) * longint'(x);
    for (int k = 1; k <= ORDER; k++) begin
      acc += longint'(ff_tap[k]) * longint'(x_hist[k-1]);
      acc -= longint'(fb_tap[k]) * longint'(y_hist[k-1]);
    end
    y = acc >>> COEF_FRAC_BITS;
    if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
    if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
    for (int k = MAX_ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = sample_t'(y);
    return sample_t'(y);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 10) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 500) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return sample_t'($urandom);
    if (r < 85) return sample_t'(int'($urandom_range(0, 511)) - 256);
    case ($urandom_range(0, 4))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(1);
      3: return sample_t'(-1);
      default: return '0;
    endcase
  endfunction

  function automatic coef_t rand_coef(input coef_mix_e mix, input int idx);
    case (mix)
      MIX_FULL: return coef_t'($urandom);
      // feedback gain sum kept below one so the loop settles
      MIX_STABLE: begin
        if (idx >= int'(REG_FB_COEF_1)) return coef_t'(int'($urandom_range(0, 8191)) - 4096);
        return coef_t'(int'($urandom_range(0, 32767)) - 16384);
      end
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return COEF_ONE;
          3: return -COEF_ONE;
          default: return '0;
        endcase
      end
      default: return (idx == int'(REG_FF_COEF_0)) ? COEF_ONE : coef_t'(0);
    endcase
  endfunction

  task automatic write_coef(input cfg_idx_t idx, input coef_t val);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (cfg_reg_e'(idx))
      REG_FF_COEF_0: ff_tap[0] = val;
      REG_FF_COEF_1: ff_tap[1] = val;
      REG_FF_COEF_2: ff_tap[2] = val;
      REG_FF_COEF_3: ff_tap[3] = val;
      REG_FB_COEF_1: fb_tap[1] = val;
      REG_FB_COEF_2: fb_tap[2] = val;
      REG_FB_COEF_3: fb_tap[3] = val;
      default: ;
    endcase
  endtask

  task automatic write_taps(input coef_t f0, input coef_t f1, input coef_t f2, input coef_t f3,
                            input coef_t b1, input coef_t b2, input coef_t b3);
    write_coef(REG_FF_COEF_0, f0);
    write_coef(REG_FF_COEF_1, f1);
    write_coef(REG_FF_COEF_2, f2);
    write_coef(REG_FF_COEF_3, f3);
    write_coef(REG_FB_COEF_1, b1);
    write_coef(REG_FB_COEF_2, b2);
    write_coef(REG_FB_COEF_3, b3);
    cfg_valid_q <= 1'b0;
  endtask

  // checked mid-cycle so the driver's updates at the edge are already visible
  task automatic wait_idle();
    while (raw_samples.size() != 0 || in_valid_q || filtered_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Sample driver
  int in_gap     = 0;
  int in_calm    = 0;
  int sent_count = 0;
  bit draining   = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      if (in_valid_q && in_if.ready) begin
        filtered_due.push_back(predict_filtered(in_sample_q));
        sent_count++;
        if (sent_count % 250 == 125) draining = 1'b1;
      end
      if (draining && filtered_due.size() == 0) draining = 1'b0;
      if (!in_valid_q || in_if.ready) begin
        if (draining || raw_samples.size() == 0) begin
          in_valid_q <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap--;
          in_valid_q <= 1'b0;
        end else begin
          in_valid_q  <= 1'b1;
          in_sample_q <= raw_samples.pop_front();
          in_gap = gap_len(in_calm);
        end
      end
    end
  end

  // Result monitor with random back-pressure
  int out_stall = 0;
  int out_calm  = 0;

  always @(posedge clk_i) begin : out_monitor
    sample_t want;
    if (!rst_ni) begin
      out_ready_q <= 1'b0;
    end else begin
      if (out_if.valid && out_ready_q) begin
        if (filtered_due.size() == 0) begin
          $error("sample_out: no request outstanding, got %0d", out_if.sample_out);
          fail_count++;
        end else begin
          want = filtered_due.pop_front();
          if (out_if.sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, out_if.sample_out);
            fail_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
        out_stall = gap_len(out_calm);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    coef_mix_e mix;
    int        n_items;
    ff_tap[0] = COEF_ONE;
    for (int k = 1; k <= MAX_ORDER; k++) begin
      ff_tap[k] = '0;
      fb_tap[k] = '0;
    end
    for (int k = 0; k < MAX_ORDER; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start-up: ff_coef_0 left at its reset value, histories still zero
    write_coef(REG_FF_COEF_1, coef_t'(8192));
    write_coef(REG_FF_COEF_2, coef_t'(-4096));
    write_coef(REG_FF_COEF_3, coef_t'(2048));
    write_coef(REG_FB_COEF_1, coef_t'(-8192));
    write_coef(REG_FB_COEF_2, coef_t'(4096));
    write_coef(REG_FB_COEF_3, coef_t'(-1024));
    write_coef(REG_UNUSED, COEF_MAX);
    cfg_valid_q <= 1'b0;
    raw_samples.push_back(sample_t'(1000));
    raw_samples.push_back(sample_t'(-1000));
    raw_samples.push_back(SAMPLE_MAX);
    raw_samples.push_back(SAMPLE_MIN);
    raw_samples.push_back('0);
    raw_samples.push_back(sample_t'(12345));
    wait_idle();

    // Extreme taps, driving both saturation limits
    write_taps(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN);
    repeat (3) raw_samples.push_back(SAMPLE_MAX);
    repeat (3) raw_samples.push_back(SAMPLE_MIN);
    raw_samples.push_back('0);
    raw_samples.push_back(sample_t'(1));
    wait_idle();

    write_taps(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
    raw_samples.push_back(SAMPLE_MAX);
    raw_samples.push_back(SAMPLE_MIN);
    raw_samples.push_back(sample_t'(-1));
    raw_samples.push_back(sample_t'(1));
    raw_samples.push_back(sample_t'(16'h5555));
    raw_samples.push_back(sample_t'(16'haaaa));
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      mix = coef_mix_e'($urandom_range(int'(MIX_FULL), int'(MIX_IDENTITY)));
      for (int r = 0; r < NUM_REGS; r++) write_coef(cfg_idx_t'(r), rand_coef(mix, r));
      if ($urandom_range(0, 3) == 0) write_coef(REG_UNUSED, coef_t'($urandom));
      cfg_valid_q <= 1'b0;
      n_items = $urandom_range(80, 120);
      for (int i = 0; i < n_items; i++) raw_samples.push_back(rand_sample());
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/iirf_pkg.sv
hdl/iirf_in_if.sv
hdl/iirf_out_if.sv
hdl/iirf_cfg_if.sv
hdl/iirf_tap_cell.sv
hdl/iirf_recursion.sv
hdl/iir_direct_form_filter.sv
tb/testbench.sv
